@@ rtl/core/rlcd_pkg.sv @@
// Shared types and constants for the row lane center detector.
package rlcd_pkg;

    localparam int PIXEL_W   = 8;
    localparam int FIELD_W   = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int THR_W     = 8;
    localparam int GAP_W     = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 3'd4;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RST    = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = 12'd10;
    localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd50;
    localparam logic [GAP_W-1:0] MIN_GAP_RST      = 11'd50;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] sample_index;
        logic [FIELD_W-1:0] row_number;
        logic [FIELD_W-1:0] center_column;
    } rlcd_result_t;

endpackage

@@ rtl/core/rlcd_row_scan.sv @@
// Per-pixel row scanner: column/row counters, edge maxima and the sample schedule.
module rlcd_row_scan
    import rlcd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [PIXEL_W-1:0]                   pixel,
    input  logic                                 frame_start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      eff_height,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      eff_samples,
    input  logic [THR_W-1:0]                     threshold,
    input  logic [GAP_W-1:0]                     min_gap,
    output logic                                 res_valid,
    output rlcd_result_t                         res
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_HEIGHT * MAX_HEIGHT + 1);
    localparam int DW = (CW + 1 > FIELD_W + 1) ? CW + 1 : FIELD_W + 1;

    logic [CW-1:0]      col_reg, col_next, col;
    logic [HW-1:0]      row_reg, row_next, row;
    logic [HW-1:0]      ns_reg, ns_next, ns;
    logic [AW-1:0]      sth_reg, sth_next, sth;
    logic [AW-1:0]      rts_reg, rts_next, rts;
    logic [PIXEL_W-1:0] lv_reg, lv_next, lv;
    logic [PIXEL_W-1:0] rv_reg, rv_next, rv;
    logic [CW-1:0]      lc_reg, lc_next, lc;
    logic [CW-1:0]      rc_reg, rc_next, rc;
    logic [WW-1:0]      mid;
    logic [WW-1:0]      col_w;
    logic               row_end;
    logic               emit;
    logic [AW:0]        sched_lhs, sched_rhs;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] center_wide;
    logic               gap_ok;
    logic               found;

    always_comb
    begin
        // A frame start acts on this very pixel: it is row 0, column 0.
        col = frame_start ? '0 : col_reg;
        row = frame_start ? '0 : row_reg;
        ns  = frame_start ? HW'(1) : ns_reg;
        sth = frame_start ? '0 : sth_reg;
        rts = frame_start ? '0 : rts_reg;

        mid   = eff_width >> 1;
        col_w = WW'(col);

        if (col == '0)
        begin
            lv = '0;
            rv = '0;
            lc = CW'(mid);
            rc = CW'(mid);
        end
        else
        begin
            lv = lv_reg;
            rv = rv_reg;
            lc = lc_reg;
            rc = rc_reg;
        end

        lv_next = lv;
        lc_next = lc;
        rv_next = rv;
        rc_next = rc;
        // Left half keeps the last of equal maxima (nearest the center).
        if (col_w >= WW'(1) && col_w <= mid && pixel >= lv)
        begin
            lv_next = pixel;
            lc_next = col;
        end
        // Right half keeps the first of equal maxima.
        if (col_w >= mid && col_w <= eff_width - WW'(2) && pixel > rv)
        begin
            rv_next = pixel;
            rc_next = col;
        end

        row_end   = col_w >= eff_width - WW'(1);
        sched_lhs = (AW + 1)'(sth) + (AW + 1)'(eff_height);
        sched_rhs = (AW + 1)'(rts) + (AW + 1)'(eff_samples);
        emit      = row_end && (ns < eff_samples) && (sched_lhs < sched_rhs);

        // The difference wraps like unsigned math; a negative gap counts as huge.
        diff        = DW'(rc_next) - DW'(lc_next);
        gap_ok      = diff[DW-1] || (diff >= DW'(min_gap));
        found       = gap_ok && (rv_next > threshold) && (lv_next > threshold);
        center_wide = DW'(lc_next) + (diff >>> 1);

        res.found         = found;
        res.center_column = found ? center_wide[FIELD_W-1:0] : '0;
        res.row_number    = FIELD_W'(row);
        res.sample_index  = FIELD_W'(ns);
        res_valid         = accept && emit;

        col_next = row_end ? '0 : col + CW'(1);
        row_next = row;
        rts_next = rts;
        ns_next  = ns;
        sth_next = sth;
        if (row_end)
        begin
            if (emit)
            begin
                ns_next  = ns + HW'(1);
                sth_next = sth + AW'(eff_height);
            end
            if (32'(row) < MAX_HEIGHT)
            begin
                row_next = row + HW'(1);
                rts_next = rts + AW'(eff_samples);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            ns_reg  <= HW'(1);
            sth_reg <= '0;
            rts_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            ns_reg  <= ns_next;
            sth_reg <= sth_next;
            rts_reg <= rts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lv_reg <= lv_next;
            lc_reg <= lc_next;
            rv_reg <= rv_next;
            rc_reg <= rc_next;
        end
    end

    a_row_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) <= MAX_HEIGHT)
        else $error("row counter passed its saturation limit");

    a_sample_advance: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> ns_reg == $past(ns) + HW'(1))
        else $error("sample index did not advance after an emitted result");

    a_column_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && row_end |=> col_reg == '0)
        else $error("column counter did not restart after row end");

endmodule

@@ rtl/core/rlcd_out_buf.sv @@
// Output register with a skid stage so the input ready never depends on m_tready directly.
module rlcd_out_buf
    import rlcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  rlcd_result_t in_data,
    output logic         can_accept,
    output logic         out_valid,
    input  logic         out_ready,
    output rlcd_result_t out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    rlcd_result_t out_data_reg, out_data_next;
    rlcd_result_t skid_data_reg, skid_data_next;
    logic         out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds data while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && in_valid))
        else $error("skid stage filled without an output stall");

endmodule

@@ rtl/core/row_lane_center_detector.sv @@
// Top level of the row lane center detector: configuration registers and stream ports.
//
// Pixels enter on the s_ stream in raster order, one transaction per pixel; s_tuser
// marks the first pixel of a frame and restarts the row, column and sample counters.
// At the last pixel of each sampled row one result transaction leaves on the m_ stream
// with the midpoint of the strongest left and right edge columns and a found flag.
// Throughput is one pixel per cycle while s_tready is high. All per-pixel work is done in the
// cycle a pixel is accepted; its result is registered in the output register when that is free.
// A skid stage behind the output register absorbs one result while m_tready is low,
// so s_tready drops only when both the output register and the skid stage are full.
// Reset puts the configuration registers at their defaults and acts as a frame start.
// Configuration writes land on cfg_we with no wait; change them only between pixels,
// and best between frames, since new values take effect on the next pixel.
module row_lane_center_detector
    import rlcd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel
    input  logic                 s_tuser,   // [0] frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [10:0] center_column, [21:11] row_number,
                                            // [32:22] sample_index, [39:33] zero
    output logic                 m_tuser    // [0] found
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] sample_count_reg;
    logic [THR_W-1:0] threshold_reg;
    logic [GAP_W-1:0] min_gap_reg;

    logic [31:0]      w_wide, h_wide, s_wide;
    logic [WW-1:0]    eff_width;
    logic [HW-1:0]    eff_height;
    logic [HW-1:0]    eff_samples;
    logic             accept;
    logic             res_valid;
    rlcd_result_t     res;
    rlcd_result_t     out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= ROW_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            sample_count_reg <= SAMPLE_COUNT_RST;
            threshold_reg    <= THRESHOLD_RST;
            min_gap_reg      <= MIN_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:    row_width_reg    <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata;
                REG_THRESHOLD:    threshold_reg    <= cfg_wdata[THR_W-1:0];
                REG_MIN_GAP:      min_gap_reg      <= cfg_wdata[GAP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_wide = 32'(row_width_reg);
        if (w_wide < 32'd4)
            w_wide = 32'd4;
        else if (w_wide > 32'(MAX_WIDTH))
            w_wide = 32'(MAX_WIDTH);

        h_wide = 32'(frame_height_reg);
        if (h_wide < 32'd1)
            h_wide = 32'd1;
        else if (h_wide > 32'(MAX_HEIGHT))
            h_wide = 32'(MAX_HEIGHT);

        // More samples than rows cannot be placed, so the count is capped at the height.
        s_wide = 32'(sample_count_reg);
        if (s_wide > h_wide)
            s_wide = h_wide;

        eff_width   = WW'(w_wide);
        eff_height  = HW'(h_wide);
        eff_samples = HW'(s_wide);
    end

    assign accept = s_tvalid && s_tready;

    rlcd_row_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_row_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (s_tdata),
        .frame_start (s_tuser),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .eff_samples (eff_samples),
        .threshold   (threshold_reg),
        .min_gap     (min_gap_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    rlcd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (res_valid),
        .in_data    (res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {7'b0, out_data.sample_index, out_data.row_number,
                      out_data.center_column};
    assign m_tuser = out_data.found;

endmodule

@@ tb/rlcd_lane_checker.sv @@
// Checker for the row lane center detector: predicts lane results and compares them.
module rlcd_lane_checker
    import rlcd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel
    input  logic                 s_tuser,   // [0] frame_start
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [39:0]          m_tdata,   // [10:0] center_column, [21:11] row_number,
                                            // [32:22] sample_index, [39:33] zero
    input  logic                 m_tuser,   // [0] found
    output int                   fail_count,
    output int                   pending,
    output int                   pixel_count,
    output int                   result_count,
    output int                   found_count,
    output int                   stall_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Register copies as last written.
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned samples_reg;
    int unsigned thr_reg;
    int unsigned gap_reg;

    // Row and frame tracking state.
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned left_val;
    int unsigned left_col;
    int unsigned right_val;
    int unsigned right_col;
    int unsigned next_idx;
    longint unsigned idx_x_height;
    longint unsigned rows_x_samples;

    rlcd_result_t lane_q[$];

    int fails   = 0;
    int pixels  = 0;
    int results = 0;
    int founds  = 0;
    int stalls  = 0;

    function automatic void restart_frame();
        col_cnt = 0;
        row_cnt = 0;
        next_idx = 1;
        idx_x_height = 0;
        rows_x_samples = 0;
    endfunction

    // Advances the row state by one pixel; returns 1 when the pixel closes a sampled row.
    function automatic bit track_pixel(input logic [7:0] pix, input logic first_px,
                                       output rlcd_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned mid;
        int unsigned c;
        int unsigned p;
        int unsigned gap;
        int unsigned center;
        bit ok;
        bit emit;
        w = width_reg;
        if (w < 4) w = 4;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        s = (samples_reg < h) ? samples_reg : h;
        mid = w / 2;
        p = 32'(pix);
        res = '0;
        emit = 1'b0;
        if (first_px)
            restart_frame();
        c = col_cnt;
        // A new row starts with both edges parked at the middle column.
        if (c == 0) begin
            left_val = 0;
            left_col = mid;
            right_val = 0;
            right_col = mid;
        end
        // Ties go toward the middle on the left and stay with the first column on the right.
        if (c >= 1 && c <= mid && p >= left_val) begin
            left_val = p;
            left_col = c;
        end
        if (c >= mid && c <= w - 2 && p > right_val) begin
            right_val = p;
            right_col = c;
        end
        if (c >= w - 1) begin
            if (next_idx < s && idx_x_height + h < rows_x_samples + s) begin
                gap = right_col - left_col;
                ok = gap >= gap_reg && right_val > thr_reg && left_val > thr_reg;
                center = left_col + gap / 2;
                res.center_column = ok ? center[FIELD_W-1:0] : '0;
                res.row_number    = row_cnt[FIELD_W-1:0];
                res.sample_index  = next_idx[FIELD_W-1:0];
                res.found         = ok;
                emit = 1'b1;
                next_idx++;
                idx_x_height += h;
            end
            col_cnt = 0;
            if (row_cnt < MAX_HEIGHT) begin
                row_cnt++;
                rows_x_samples += s;
            end
        end else begin
            col_cnt = c + 1;
        end
        return emit;
    endfunction

    task automatic note_mismatch(input string what, input rlcd_result_t want,
                                 input rlcd_result_t got);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("%0t %s: exp c=%0d r=%0d i=%0d f=%0b, got c=%0d r=%0d i=%0d f=%0b",
                     $time, what, want.center_column, want.row_number, want.sample_index,
                     want.found, got.center_column, got.row_number, got.sample_index,
                     got.found);
    endtask

    always @(posedge clk or negedge rst_n) begin
        rlcd_result_t got;
        rlcd_result_t want;
        if (!rst_n) begin
            width_reg = ROW_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            samples_reg = SAMPLE_COUNT_RST;
            thr_reg = THRESHOLD_RST;
            gap_reg = MIN_GAP_RST;
            restart_frame();
            left_val = 0;
            left_col = 0;
            right_val = 0;
            right_col = 0;
            lane_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.center_column = m_tdata[FIELD_W-1:0];
                got.row_number    = m_tdata[2*FIELD_W-1:FIELD_W];
                got.sample_index  = m_tdata[3*FIELD_W-1:2*FIELD_W];
                got.found         = m_tuser;
                results++;
                if (got.found === 1'b1)
                    founds++;
                if (lane_q.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = lane_q.pop_front();
                    if (got !== want)
                        note_mismatch("lane result mismatch", want, got);
                end
            end
            if (s_tvalid && !s_tready)
                stalls++;
            if (s_tvalid && s_tready) begin
                pixels++;
                if (track_pixel(s_tdata, s_tuser, want))
                    lane_q.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROW_WIDTH:    width_reg = cfg_wdata;
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata;
                    REG_SAMPLE_COUNT: samples_reg = cfg_wdata;
                    REG_THRESHOLD:    thr_reg = cfg_wdata[THR_W-1:0];
                    REG_MIN_GAP:      gap_reg = cfg_wdata[GAP_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count   <= fails;
        pending      <= lane_q.size();
        pixel_count  <= pixels;
        result_count <= results;
        found_count  <= founds;
        stall_count  <= stalls;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the row lane center detector: clock, reset, pixel stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rlcd_pkg::*;

    localparam int     RANDOM_ITEMS  = 480;
    localparam int     LONG_HOLD     = 300;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     MAX_DIM       = 2048;
    localparam longint LIMIT_NS      = 20_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic                 m_tuser;

    int fail_count;
    int pending;
    int pixel_count;
    int result_count;
    int found_count;
    int stall_count;

    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int burst_left  = 0;
    int frame_total = 0;

    // Copies of the sizing and threshold registers, used only to shape the frames and their pixels.
    logic [CFG_W-1:0] width_now  = ROW_WIDTH_RST;
    logic [CFG_W-1:0] height_now = FRAME_HEIGHT_RST;
    logic [7:0]       thr_now    = THRESHOLD_RST;

    // Three rows of eight: an unsampled row, a row with ties on both sides, a dark row.
    logic [7:0] lane_rows [24] = '{
        8'd255, 8'd0,   8'd0,  8'd0,   8'd0,  8'd0,   8'd0,   8'd255,
        8'd255, 8'd120, 8'd80, 8'd120, 8'd60, 8'd200, 8'd200, 8'd255,
        8'd0,   8'd0,   8'd0,  8'd0,   8'd0,  8'd50,  8'd0,   8'd0
    };

    row_lane_center_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rlcd_lane_checker lane_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .pixel_count  (pixel_count),
        .result_count (result_count),
        .found_count  (found_count),
        .stall_count  (stall_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_width();
        if (width_now < 4)
            return 4;
        if (width_now > MAX_DIM)
            return MAX_DIM;
        return int'(width_now);
    endfunction

    function automatic int eff_height();
        if (height_now < 1)
            return 1;
        if (height_now > MAX_DIM)
            return MAX_DIM;
        return int'(height_now);
    endfunction

    // Mix of uniform noise, values around the threshold, repeats for ties and the extremes.
    function automatic logic [7:0] pick_pixel(input logic [7:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(0, 255));
            4, 5:       return 8'($urandom_range(0, thr_now));
            6:          return prev;
            7:          return thr_now;
            8:          return (thr_now == 8'd255) ? thr_now : thr_now + 8'd1;
            default:    return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // Offers one pixel and returns at the edge where the transaction completes.
    task automatic send_pixel(input logic [7:0] pix, input logic first_px);
        int gap_len;
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= first_px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_run(input int count, input logic with_start);
        logic [7:0] pix;
        pix = 8'd0;
        for (int k = 0; k < count; k++) begin
            pix = pick_pixel(pix);
            send_pixel(pix, with_start && k == 0);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [4:0] mask, input logic [CFG_W-1:0] w,
                                input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] smp,
                                input logic [CFG_W-1:0] thr_word,
                                input logic [CFG_W-1:0] gap_word);
        if (mask[REG_ROW_WIDTH]) begin
            write_reg(REG_ROW_WIDTH, w);
            width_now = w;
        end
        if (mask[REG_FRAME_HEIGHT]) begin
            write_reg(REG_FRAME_HEIGHT, h);
            height_now = h;
        end
        if (mask[REG_SAMPLE_COUNT])
            write_reg(REG_SAMPLE_COUNT, smp);
        if (mask[REG_THRESHOLD]) begin
            write_reg(REG_THRESHOLD, thr_word);
            thr_now = thr_word[THR_W-1:0];
        end
        if (mask[REG_MIN_GAP])
            write_reg(REG_MIN_GAP, gap_word);
        cfg_we <= 1'b0;
    endtask

    // Stops offering pixels and waits until every predicted result has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The receiver switches among stall patterns; once asked, it holds off for a long stretch.
    initial
    begin : result_sink
        int seg_left;
        int mode;
        seg_left = 0;
        mode = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #LIMIT_NS;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int w;
        int h;
        int smp;
        int thr;
        int gap_val;
        int full;
        int count;
        int nframes;
        int random_px;
        logic [4:0] mask;
        logic with_start;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ROW_WIDTH;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame. The first pixel carries no frame start, since reset acts as one.
        program_regs(5'h1f, 12'd8, 12'd3, 12'd3, 12'd50, 12'd0);
        foreach (lane_rows[k])
            send_pixel(lane_rows[k], 1'b0);
        frame_total++;
        settle();

        // Small random frames under many settings, with cut-short frames and continuations.
        random_px = 0;
        while (random_px < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 3) != 0) ? $urandom_range(4, 12) : $urandom_range(0, 40);
            h = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : 0;
            smp = ($urandom_range(0, 9) != 0) ? $urandom_range(0, h + 3) : 4095;
            case ($urandom_range(0, 4))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(0, 200);
            endcase
            gap_val = ($urandom_range(0, 9) == 0) ? 2047 : $urandom_range(0, w);
            mask = (random_px == 0) ? 5'h1f : 5'($urandom_range(1, 31));
            program_regs(mask, 12'(w), 12'(h), 12'(smp),
                         {4'($urandom_range(0, 15)), 8'(thr)},
                         {1'($urandom_range(0, 1)), 11'(gap_val)});
            nframes = $urandom_range(1, 3);
            repeat (nframes) begin
                full = eff_width() * eff_height();
                with_start = 1'b1;
                case ($urandom_range(0, 9))
                    0: count = $urandom_range(1, full);
                    1:
                    begin
                        count = $urandom_range(1, full);
                        with_start = 1'b0;
                    end
                    default:
                    begin
                        count = full;
                        if ($urandom_range(0, 3) == 0)
                            count += $urandom_range(1, 2 * eff_width());
                    end
                endcase
                send_run(count, with_start);
                random_px += count;
                frame_total++;
            end
            settle();
        end

        // Narrowest rows with the tallest frame and every row sampled, so nearly every row
        // gives a result. The receiver holds off partway so the input backs up.
        program_regs(5'h1f, 12'd0, 12'd4095, 12'd4095, 12'($urandom_range(0, 255)), 12'd0);
        send_run(40, 1'b1);
        hold_req = 1'b1;
        send_run(160, 1'b0);
        frame_total++;
        settle();

        // Widest rows, cut short; the width is then narrowed mid-row, so the column
        // already lies past the row end and the following rows are narrow.
        program_regs(5'h1f, 12'd4095, 12'd2, 12'd2, 12'd60, 12'd1500);
        send_run(64, 1'b1);
        settle();
        mask = '0;
        mask[REG_ROW_WIDTH] = 1'b1;
        mask[REG_MIN_GAP] = 1'b1;
        program_regs(mask, 12'd8, 12'd0, 12'd0, 12'd0, 12'd2);
        send_run(40, 1'b0);
        frame_total++;
        settle();

        $display("Streamed %0d pixels in %0d frames; %0d lane results checked, %0d found.",
                 pixel_count, frame_total, result_count, found_count);
        $display("Pixel input was held off by output back-pressure for %0d cycles.",
                 stall_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
